/* src/blt_pkg.sv */
`default_nettype none

package blt_pkg;

  // Field and register widths
  localparam int EL_W     = 10;
  localparam int LEN_W    = 11;
  localparam int SIZE_W   = 7;
  localparam int SPEED_W  = 16;
  localparam int COOL_W   = 20;
  localparam int BRIGHT_W = 8;
  localparam int IDX_W    = 10;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 3;

  // Strip and trail limits
  localparam int MAX_LENGTH = 1024;
  localparam int MAX_TRAIL  = 64;

  // Position: signed pixels with FRAC_W fraction bits
  localparam int FRAC_W = 8;
  localparam int POS_W  = 21;
  localparam int HEAD_W = POS_W - FRAC_W;

  // Brightness ramp divisor (trail size minus one)
  localparam int DIV_W = (MAX_TRAIL > 2) ? $clog2(MAX_TRAIL) : 1;

  // Queue between front and back
  localparam int QDEPTH = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRIGHTNESS = 3'd4;

  // Register reset values
  localparam logic [LEN_W-1:0]    RST_STRIP_LENGTH   = 11'd144;
  localparam logic [SIZE_W-1:0]   RST_TRAIL_SIZE     = 7'd8;
  localparam logic [SPEED_W-1:0]  RST_SPEED          = 16'd7680;
  localparam logic [COOL_W-1:0]   RST_COOLDOWN       = 20'd1024;
  localparam logic [BRIGHT_W-1:0] RST_MAX_BRIGHTNESS = 8'd255;

  // One tick's drawing job, handed from front to back
  typedef struct packed {
    logic                draw;
    logic                backward;
    logic [HEAD_W-1:0]   head;
    logic [LEN_W-1:0]    len;
    logic [SIZE_W-1:0]   size;
    logic [BRIGHT_W-1:0] max_bright;
  } job_t;

endpackage

`default_nettype wire

/* src/blt_queue.sv */
`default_nettype none

module blt_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire blt_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output blt_pkg::job_t      pop_job,
  output logic               empty
);
  import blt_pkg::*;

  localparam int QA_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W = $clog2(QDEPTH + 1);

  job_t            entries [QDEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;

  assign full    = (count == QC_W'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_job = entries[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("job popped from an empty queue");

endmodule

`default_nettype wire

/* src/blt_front.sv */
`default_nettype none

module blt_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [blt_pkg::EL_W-1:0]        elapsed,
  input  wire logic                            cfg_we,
  input  wire logic [blt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [blt_pkg::CFG_W-1:0]       cfg_data,
  output logic                                 push,
  output blt_pkg::job_t                        push_job,
  input  wire logic                            q_full
);
  import blt_pkg::*;

  localparam int PROD_W = SPEED_W + EL_W;
  localparam int EXT_W  = POS_W + 1;

  typedef enum logic [1:0] {F_IDLE, F_MOVE, F_PUSH} fstate_t;

  fstate_t state;

  // Configuration registers
  logic [LEN_W-1:0]    strip_length;
  logic [SIZE_W-1:0]   trail_size;
  logic [SPEED_W-1:0]  speed;
  logic [COOL_W-1:0]   cooldown;
  logic [BRIGHT_W-1:0] max_brightness;

  // Animation state
  logic signed [POS_W-1:0] pos;
  logic                    backward;
  logic                    cooling;
  logic [COOL_W-1:0]       cool_clock;

  // Per-tick registers
  job_t                job;
  logic [SPEED_W-1:0]  step;

  // Tick classification
  logic [LEN_W-1:0]    len_c;
  logic [SIZE_W-1:0]   size_c;
  logic                round_up;
  logic [HEAD_W-1:0]   head;
  job_t                job_next;
  logic [PROD_W-1:0]   prod;
  logic [COOL_W:0]     clock_sum;
  logic [COOL_W-1:0]   clock_sat;

  // Position advance and bounce
  logic signed [EXT_W-1:0] delta;
  logic signed [EXT_W-1:0] pos1;
  logic signed [EXT_W-1:0] pos2;
  logic [LEN_W:0]          len_plus_size;
  logic signed [EXT_W-1:0] fwd_lim;
  logic signed [EXT_W-1:0] len_fix;
  logic signed [EXT_W-1:0] back_lim;
  logic                    fwd_hit;
  logic                    back2;
  logic                    back_hit;
  logic signed [POS_W-1:0] pos_next;
  logic                    backward_next;

  assign in_stall = (state != F_IDLE);
  assign push     = (state == F_PUSH) && !q_full;
  assign push_job = job;

  // Clamp strip and trail to their limits
  assign len_c  = (strip_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : strip_length;
  assign size_c = (trail_size > SIZE_W'(MAX_TRAIL)) ? SIZE_W'(MAX_TRAIL) : trail_size;

  // Truncate position toward zero for the head pixel
  assign round_up = pos[POS_W-1] && (pos[FRAC_W-1:0] != '0);
  assign head     = pos[POS_W-1:FRAC_W] + {{(HEAD_W-1){1'b0}}, round_up};

  always_comb begin
    job_next.draw       = !cooling;
    job_next.backward   = backward;
    job_next.head       = head;
    job_next.len        = len_c;
    job_next.size       = size_c;
    job_next.max_bright = max_brightness;
  end

  // Distance for this tick
  assign prod = PROD_W'(speed) * PROD_W'(elapsed);

  // Cooldown clock, saturating
  assign clock_sum = {1'b0, cool_clock} + (COOL_W+1)'(elapsed);
  assign clock_sat = clock_sum[COOL_W] ? '1 : clock_sum[COOL_W-1:0];

  // Advance position, then check both ends in order
  assign delta         = backward ? -$signed(EXT_W'(step)) : $signed(EXT_W'(step));
  assign pos1          = EXT_W'(pos) + delta;
  assign len_plus_size = {1'b0, job.len} + (LEN_W+1)'(job.size);
  assign fwd_lim       = $signed({{(EXT_W-LEN_W-1-FRAC_W){1'b0}}, len_plus_size,
                                  {FRAC_W{1'b0}}});
  assign len_fix       = $signed({{(EXT_W-LEN_W-FRAC_W){1'b0}}, job.len, {FRAC_W{1'b0}}});
  assign back_lim      = -$signed({{(EXT_W-SIZE_W-FRAC_W){1'b0}}, job.size,
                                   {FRAC_W{1'b0}}});
  assign fwd_hit       = !backward && (pos1 >= fwd_lim);
  assign pos2          = fwd_hit ? len_fix : pos1;
  assign back2         = backward || fwd_hit;
  assign back_hit      = back2 && (pos2 <= back_lim);
  assign pos_next      = back_hit ? '0 : pos2[POS_W-1:0];
  assign backward_next = back2 && !back_hit;

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= F_IDLE;
      strip_length   <= RST_STRIP_LENGTH;
      trail_size     <= RST_TRAIL_SIZE;
      speed          <= RST_SPEED;
      cooldown       <= RST_COOLDOWN;
      max_brightness <= RST_MAX_BRIGHTNESS;
      pos            <= '0;
      backward       <= 1'b0;
      cooling        <= 1'b0;
      cool_clock     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STRIP_LENGTH:   strip_length   <= cfg_data[LEN_W-1:0];
          CFG_TRAIL_SIZE:     trail_size     <= cfg_data[SIZE_W-1:0];
          CFG_SPEED:          speed          <= cfg_data[SPEED_W-1:0];
          CFG_COOLDOWN:       cooldown       <= cfg_data[COOL_W-1:0];
          CFG_MAX_BRIGHTNESS: max_brightness <= cfg_data[BRIGHT_W-1:0];
          default: ;
        endcase
      end
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            job  <= job_next;
            step <= prod[PROD_W-1:EL_W];
            if (cooling) begin
              cool_clock <= clock_sat;
              if (clock_sat >= cooldown) begin
                cooling <= 1'b0;
              end
              state <= F_PUSH;
            end else begin
              state <= F_MOVE;
            end
          end
        end
        F_MOVE: begin
          pos      <= pos_next;
          backward <= backward_next;
          if (fwd_hit || back_hit) begin
            cooling    <= 1'b1;
            cool_clock <= '0;
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/blt_back.sv */
`default_nettype none

module blt_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire blt_pkg::job_t                 pop_job,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [blt_pkg::IDX_W-1:0]          pixel_index,
  output logic [blt_pkg::BRIGHT_W-1:0]       brightness,
  output logic                               pixel_valid,
  output logic                               last
);
  import blt_pkg::*;

  localparam int P_W   = HEAD_W + 1;
  localparam int CNT_W = $clog2(BRIGHT_W);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_WALK, B_EMPTY} bstate_t;

  bstate_t state;

  job_t                   jb;
  logic signed [P_W-1:0]  p;
  logic [SIZE_W-1:0]      i;
  logic [BRIGHT_W-1:0]    q;
  logic [DIV_W-1:0]       r;
  logic [DIV_W-1:0]       d;
  logic [BRIGHT_W-1:0]    dvd;
  logic [DIV_W-1:0]       rem;
  logic [CNT_W-1:0]       div_cnt;

  logic                   out_free;
  logic                   emit;
  logic signed [P_W-1:0]  p_next;
  logic                   p_in;
  logic                   pn_in;
  logic [SIZE_W-1:0]      size_m1;
  logic                   last_pix;
  logic [BRIGHT_W-1:0]    bright;
  logic [DIV_W:0]         shift_rem;
  logic [DIV_W:0]         shift_diff;
  logic                   shift_ge;
  logic [DIV_W:0]         rsum;
  logic [DIV_W:0]         rdiff;
  logic                   r_ge;
  logic [BRIGHT_W-1:0]    ramp_num;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == B_IDLE) && !q_empty;

  // Load a new beat into the output register when it is free
  assign emit = out_free && (((state == B_WALK) && p_in) || (state == B_EMPTY));

  // Trail walk: pixel positions and the last one on the strip
  assign p_next   = jb.backward ? p + 1'b1 : p - 1'b1;
  assign p_in     = !p[P_W-1] && (p[P_W-2:0] < (P_W-1)'(jb.len));
  assign pn_in    = !p_next[P_W-1] && (p_next[P_W-2:0] < (P_W-1)'(jb.len));
  assign size_m1  = jb.size - 1'b1;
  assign last_pix = (i == size_m1) || !pn_in;

  // Brightness ramp falls from the head; a zero level ramps up to one
  assign bright   = (jb.max_bright == '0) ? q : jb.max_bright - q;
  assign ramp_num = (pop_job.max_bright == '0) ? BRIGHT_W'(1) : pop_job.max_bright - 1'b1;

  // One restoring divide step per cycle
  assign shift_rem  = {rem, dvd[BRIGHT_W-1]};
  assign shift_diff = shift_rem - {1'b0, d};
  assign shift_ge   = (shift_rem >= {1'b0, d});

  // Running quotient and remainder of i * num / d
  assign rsum  = {1'b0, r} + {1'b0, rem};
  assign rdiff = rsum - {1'b0, d};
  assign r_ge  = (rsum >= {1'b0, d});

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            jb      <= pop_job;
            p       <= {pop_job.head[HEAD_W-1], pop_job.head};
            i       <= '0;
            q       <= '0;
            r       <= '0;
            d       <= DIV_W'(pop_job.size - 1'b1);
            dvd     <= ramp_num;
            rem     <= '0;
            div_cnt <= CNT_W'(BRIGHT_W - 1);
            if (!pop_job.draw || (pop_job.size == '0)) begin
              state <= B_EMPTY;
            end else if (pop_job.size == SIZE_W'(1)) begin
              state <= B_WALK;
            end else begin
              state <= B_DIV;
            end
          end
        end
        B_DIV: begin
          rem     <= shift_ge ? shift_diff[DIV_W-1:0] : shift_rem[DIV_W-1:0];
          dvd     <= {dvd[BRIGHT_W-2:0], shift_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            state <= B_WALK;
          end
        end
        B_WALK: begin
          if (p_in) begin
            if (out_free) begin
              pixel_index <= p[IDX_W-1:0];
              brightness  <= bright;
              pixel_valid <= 1'b1;
              last        <= last_pix;
              p           <= p_next;
              i           <= i + 1'b1;
              r           <= r_ge ? rdiff[DIV_W-1:0] : rsum[DIV_W-1:0];
              q           <= q + dvd + BRIGHT_W'(r_ge);
              if (last_pix) begin
                state <= B_IDLE;
              end
            end
          end else if (i == size_m1) begin
            state <= B_EMPTY;
          end else begin
            p <= p_next;
            i <= i + 1'b1;
            r <= r_ge ? rdiff[DIV_W-1:0] : rsum[DIV_W-1:0];
            q <= q + dvd + BRIGHT_W'(r_ge);
          end
        end
        B_EMPTY: begin
          if (out_free) begin
            pixel_index <= '0;
            brightness  <= '0;
            pixel_valid <= 1'b0;
            last        <= 1'b1;
            state       <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pixel_valid) |-> last)
    else $error("empty result without last");
  a_div_needs_ramp: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (jb.size > SIZE_W'(1)))
    else $error("ramp divide started with a trail of one pixel or less");

endmodule

`default_nettype wire

/* src/bouncing_led_trail_generator.sv */
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+--------------------------------------------
// in       | input     | in_valid / in_stall | elapsed
// out      | output    | out_valid/out_stall | pixel_index, brightness, pixel_valid, last
// cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// The front takes a tick only when idle, moves the trail unless cooling, and
// pushes a job, holding while the job queue is full. The back pops a job, runs a
// restoring divide for the brightness ramp when trail_size > 1, then walks the
// trail up to the last lit pixel or sends an empty beat; the back sets the rate.
// Reset is synchronous with no clearing pass; a stalled output beat holds while
// the front keeps filling the two-entry queue.
`default_nettype none

module bouncing_led_trail_generator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [blt_pkg::EL_W-1:0]        elapsed,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [blt_pkg::IDX_W-1:0]            pixel_index,
  output logic [blt_pkg::BRIGHT_W-1:0]         brightness,
  output logic                                 pixel_valid,
  output logic                                 last,
  input  wire logic                            cfg_we,
  input  wire logic [blt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [blt_pkg::CFG_W-1:0]       cfg_data
);
  import blt_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  // Accept ticks, update motion state, queue drawing jobs
  blt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .elapsed   (elapsed),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  // Decouple front and back
  blt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // Walk the trail and emit pixel beats
  blt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .pop_job     (pop_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .brightness  (brightness),
    .pixel_valid (pixel_valid),
    .last        (last)
  );

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import blt_pkg::*;

  localparam int CLOCK_MAX   = 1048575;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 20;
  localparam int PHASE_TICKS = 29;

  // No register lives at this index; writes to it change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [BRIGHT_W-1:0] br;
    logic                pv;
    logic                last;
  } pixel_beat_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     value;
    logic [EL_W-1:0]      el;
    logic                 typed;
    pixel_beat_t          want;
  } stim_row_t;

  localparam pixel_beat_t EMPTY_BEAT = '{idx: '0, br: '0, pv: 1'b0, last: 1'b1};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [EL_W-1:0]      elapsed = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IDX_W-1:0]     pixel_index;
  logic [BRIGHT_W-1:0]  brightness;
  logic                 pixel_valid;
  logic                 last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  bouncing_led_trail_generator DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .elapsed     (elapsed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .brightness  (brightness),
    .pixel_valid (pixel_valid),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow registers and trail state
  logic [LEN_W-1:0]    r_len;
  logic [SIZE_W-1:0]   r_size;
  logic [SPEED_W-1:0]  r_speed;
  logic [COOL_W-1:0]   r_cool;
  logic [BRIGHT_W-1:0] r_max;
  int                  trail_pos;
  bit                  trail_back;
  bit                  in_cooldown;
  int                  cool_clock;

  pixel_beat_t pending_beats[$];
  pixel_beat_t tick_beats[$];
  stim_row_t   stim_rows[$];

  int errors = 0;
  int beat_num = 0;
  int quiet = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  task automatic report(input string msg);
    if (errors < 100) $display("MISMATCH %s", msg);
    errors++;
  endtask

  // Compute the pixel beats of one tick and advance the trail
  task automatic advance_trail(input logic [EL_W-1:0] el);
    int len, size, dir, head, p, b, step, c, i;
    pixel_beat_t beat;
    tick_beats.delete();
    if (in_cooldown) begin
      c = cool_clock + int'(el);
      if (c > CLOCK_MAX) c = CLOCK_MAX;
      cool_clock = c;
      if (cool_clock >= int'(r_cool)) in_cooldown = 1'b0;
    end else begin
      len  = (int'(r_len) > MAX_LENGTH) ? MAX_LENGTH : int'(r_len);
      size = (int'(r_size) > MAX_TRAIL) ? MAX_TRAIL : int'(r_size);
      dir  = trail_back ? -1 : 1;
      head = (trail_pos >= 0) ? (trail_pos >>> FRAC_W) : -((-trail_pos) >>> FRAC_W);
      // draw the trail, brightest at the head unless max brightness is zero
      for (i = 0; i < size; i++) begin
        p = head - i * dir;
        if (p >= 0 && p < len) begin
          if (size <= 1) b = int'(r_max);
          else b = int'(r_max) + (i * (1 - int'(r_max))) / (size - 1);
          beat.idx  = p[IDX_W-1:0];
          beat.br   = b[BRIGHT_W-1:0];
          beat.pv   = 1'b1;
          beat.last = 1'b0;
          tick_beats.push_back(beat);
        end
      end
      // move, then bounce off either end
      step = (int'(r_speed) * int'(el)) >>> 10;
      trail_pos += dir * step;
      if (!trail_back && trail_pos >= (len + size) * 256) begin
        trail_back  = 1'b1;
        trail_pos   = len * 256;
        cool_clock  = 0;
        in_cooldown = 1'b1;
      end
      if (trail_back && trail_pos <= -(size * 256)) begin
        trail_back  = 1'b0;
        trail_pos   = 0;
        cool_clock  = 0;
        in_cooldown = 1'b1;
      end
    end
    if (tick_beats.size() == 0) tick_beats.push_back(EMPTY_BEAT);
    beat = tick_beats.pop_back();
    beat.last = 1'b1;
    tick_beats.push_back(beat);
  endtask

  // Offer one tick beat; hold it until taken, then queue what it should draw
  task automatic send_tick(input logic [EL_W-1:0] el, input bit typed = 1'b0,
                           input pixel_beat_t want = EMPTY_BEAT);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    elapsed  = el;
    do @(posedge clk); while (in_stall);
    advance_trail(el);
    if (typed) pending_beats.push_back(want);
    else foreach (tick_beats[k]) pending_beats.push_back(tick_beats[k]);
    @(negedge clk);
  endtask

  // Drop valid and let the block drain before touching registers
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_STRIP_LENGTH:   r_len   = val[LEN_W-1:0];
      CFG_TRAIL_SIZE:     r_size  = val[SIZE_W-1:0];
      CFG_SPEED:          r_speed = val[SPEED_W-1:0];
      CFG_COOLDOWN:       r_cool  = val[COOL_W-1:0];
      CFG_MAX_BRIGHTNESS: r_max   = val[BRIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic add_row(input row_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_W-1:0] val, input logic [EL_W-1:0] el,
                         input bit typed, input pixel_beat_t want);
    stim_row_t row;
    row.kind    = kind;
    row.reg_idx = idx;
    row.value   = val;
    row.el      = el;
    row.typed   = typed;
    row.want    = want;
    stim_rows.push_back(row);
  endtask

  function automatic logic [EL_W-1:0] pick_elapsed();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return EL_W'($urandom_range(1023));
    endcase
  endfunction

  // Random settings, biased toward short strips so the trail bounces often
  task automatic run_phase(input int idle, input int stall, input bit hold, input bit pause);
    int v, n;
    wait_idle();
    case ($urandom_range(9))
      0: v = 1;
      1: v = MAX_LENGTH;
      2: v = $urandom_range(1025, 2047);
      3: v = 0;
      default: v = $urandom_range(2, 48);
    endcase
    write_reg(CFG_STRIP_LENGTH, CFG_W'(v));
    case ($urandom_range(9))
      0: v = 1;
      1: v = MAX_TRAIL;
      2: v = $urandom_range(65, 127);
      3: v = 0;
      default: v = $urandom_range(2, 20);
    endcase
    write_reg(CFG_TRAIL_SIZE, CFG_W'(v));
    case ($urandom_range(7))
      0: v = 0;
      1: v = 65535;
      2: v = $urandom_range(65535);
      default: v = $urandom_range(2000, 65535);
    endcase
    write_reg(CFG_SPEED, CFG_W'(v));
    case ($urandom_range(7))
      0: v = 0;
      1: v = $urandom_range(4096, 20000);
      default: v = $urandom_range(3000);
    endcase
    write_reg(CFG_COOLDOWN, CFG_W'(v));
    case ($urandom_range(7))
      0: v = 1;
      1: v = 255;
      2: v = 0;
      default: v = $urandom_range(1, 255);
    endcase
    write_reg(CFG_MAX_BRIGHTNESS, CFG_W'(v));
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) hold_req++;
    for (n = 0; n < PHASE_TICKS; n++) begin
      // pause the sender until every pending beat is out
      if (pause && n == PHASE_TICKS / 2) begin
        in_valid = 1'b0;
        while (pending_beats.size() != 0) @(negedge clk);
      end
      send_tick(pick_elapsed());
    end
  endtask

  // Receiver stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Check each output beat against the oldest pending one
  always @(posedge clk) begin
    pixel_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing pending", beat_num));
      end else begin
        want = pending_beats.pop_front();
        if (pixel_index !== want.idx)
          report($sformatf("beat %0d pixel_index: got %0d, expected %0d",
                           beat_num, pixel_index, want.idx));
        if (brightness !== want.br)
          report($sformatf("beat %0d brightness: got %0d, expected %0d",
                           beat_num, brightness, want.br));
        if (pixel_valid !== want.pv)
          report($sformatf("beat %0d pixel_valid: got %0b, expected %0b",
                           beat_num, pixel_valid, want.pv));
        if (last !== want.last)
          report($sformatf("beat %0d last: got %0b, expected %0b",
                           beat_num, last, want.last));
      end
      beat_num++;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("bouncing_led_trail_generator regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int m, k;
    bit prev_tick;

    r_len       = RST_STRIP_LENGTH;
    r_size      = RST_TRAIL_SIZE;
    r_speed     = RST_SPEED;
    r_cool      = RST_COOLDOWN;
    r_max       = RST_MAX_BRIGHTNESS;
    trail_pos   = 0;
    trail_back  = 1'b0;
    in_cooldown = 1'b0;
    cool_clock  = 0;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed part: reset state, extremes and the special cases
    add_row(ROW_TICK, '0, '0, 10'd0, 1'b1, '{10'd0, 8'd255, 1'b1, 1'b1});
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b0, EMPTY_BEAT);
    // zero trail draws nothing
    add_row(ROW_WRITE, CFG_TRAIL_SIZE, 20'd0, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd0, 1'b1, EMPTY_BEAT);
    // single pixel at zero brightness, head at pixel 29
    add_row(ROW_WRITE, CFG_TRAIL_SIZE, 20'd1, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_WRITE, CFG_MAX_BRIGHTNESS, 20'd0, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd0, 1'b1, '{10'd29, 8'd0, 1'b1, 1'b1});
    // zero brightness ramp over a full trail
    add_row(ROW_WRITE, CFG_TRAIL_SIZE, 20'd64, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd512, 1'b0, EMPTY_BEAT);
    // long trail at full brightness and top speed
    add_row(ROW_WRITE, CFG_MAX_BRIGHTNESS, 20'd255, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_WRITE, CFG_TRAIL_SIZE, 20'd127, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_WRITE, CFG_SPEED, 20'd65535, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b0, EMPTY_BEAT);
    // long strip
    add_row(ROW_WRITE, CFG_STRIP_LENGTH, 20'd2047, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b0, EMPTY_BEAT);
    // zero strip never draws, whatever the phase
    add_row(ROW_WRITE, CFG_STRIP_LENGTH, 20'd0, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b1, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b1, EMPTY_BEAT);
    // zero cooldown on a one-pixel strip
    add_row(ROW_WRITE, CFG_COOLDOWN, 20'd0, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_WRITE, CFG_STRIP_LENGTH, 20'd1, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_WRITE, CFG_TRAIL_SIZE, 20'd1, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_WRITE, CFG_MAX_BRIGHTNESS, 20'd1, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b0, EMPTY_BEAT);
    // zero speed holds the trail in place
    add_row(ROW_WRITE, CFG_SPEED, 20'd0, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd1023, 1'b0, EMPTY_BEAT);
    // longest cooldown, and a write to an index with no register
    add_row(ROW_WRITE, CFG_COOLDOWN, 20'hFFFFF, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_WRITE, CFG_UNUSED, 20'hFFFFF, '0, 1'b0, EMPTY_BEAT);
    add_row(ROW_TICK, '0, '0, 10'd0, 1'b0, EMPTY_BEAT);

    prev_tick = 1'b0;
    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_WRITE) begin
        if (prev_tick) wait_idle();
        write_reg(stim_rows[r].reg_idx, stim_rows[r].value);
        prev_tick = 1'b0;
      end else begin
        send_tick(stim_rows[r].el, stim_rows[r].typed, stim_rows[r].want);
        prev_tick = 1'b1;
      end
    end

    // Random phases under each idling mode
    for (m = 0; m < 4; m++) begin
      for (k = 0; k < 3; k++) begin
        case (m)
          0: run_phase(0, 0, k == 0, 1'b0);
          1: run_phase(55, 0, 1'b0, k == 1);
          2: run_phase(0, 55, 1'b0, 1'b0);
          default: run_phase(16, 16, 1'b0, 1'b0);
        endcase
      end
    end

    // Drain, then let the block settle
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (pending_beats.size() != 0)
      report($sformatf("%0d beats never arrived", pending_beats.size()));

    if (errors == 0) begin
      $display("bouncing_led_trail_generator regression: pass");
    end else begin
      $display("bouncing_led_trail_generator regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/blt_pkg.sv
src/blt_queue.sv
src/blt_front.sv
src/blt_back.sv
src/bouncing_led_trail_generator.sv
verif/tb.sv
